// ----- hw/rtl/cra_pkg.sv -----
`default_nettype none
package cra_pkg;
  localparam int CHANNELS_DEF  = 16;
  localparam int TAPS_DEF      = 3;
  localparam int MAX_FRAME_DEF = 16384;
  localparam int VAL_W = 33;
  localparam int SUM_W = 46;
  localparam int CNT_W = 13;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic               frame_end;
    logic [5:0]         coef_index;
    logic signed [15:0] coef_value;
  } cra_in_t;

  typedef struct packed {
    logic [3:0]       channel;
    logic [VAL_W-1:0] mean_feature;
    logic             last_result;
  } cra_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_POOL, ST_LOAD, ST_DIV, ST_EMIT
  } cra_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_item;   // latch the accepted item
    logic mac_clear;   // load accumulator with scaled bias plus product
    logic mac_step;    // add one product
    logic pool;        // ReLU, pool, accumulate for current channel
    logic div_start;   // start divide for current channel
    logic div_step;
    logic emit;        // load output register
    logic frame_clear;
    logic win_shift;   // advance sample window
  } cra_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic item_coef;
    logic item_end;
    logic item_drop;   // sample past frame limit
    logic win_full;
    logic div_done;
  } cra_stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/cra_datapath.sv -----
`default_nettype none
module cra_datapath
  import cra_pkg::*;
#(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int TAPS      = TAPS_DEF,
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  cra_in_t   in_item,
  input  cra_cmd_t  cmd,
  input  wire logic [$clog2(CHANNELS+1)-1:0] ch,
  input  wire logic [$clog2(TAPS+1)-1:0]     tap,
  output cra_stat_t stat,
  output cra_out_t  res
);
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int NW    = CHANNELS * TAPS;
  localparam int NW_W  = (NW > 1) ? $clog2(NW) : 1;
  localparam int SC_W  = $clog2(MAX_FRAME + 1);
  localparam int HIST  = (TAPS > 1) ? TAPS - 1 : 1;
  localparam int HI_W  = (HIST > 1) ? $clog2(HIST) : 1;
  localparam int ACC_W = 40 + $clog2(TAPS + 1);
  localparam int DQ_W  = SUM_W;

  cra_in_t item_r;
  logic signed [15:0] wmem [NW];
  logic signed [15:0] bmem [CHANNELS];
  logic signed [15:0] w_rd_r, b_rd_r;
  logic signed [15:0] win_r;
  logic signed [15:0] hist_r [HIST];
  logic [TP_W-1:0] fill_r;
  logic [SC_W-1:0] scnt_r;
  logic phase_r;
  logic [CNT_W-1:0] pcnt_r;
  logic [VAL_W-1:0] pfirst_r [CHANNELS];
  logic [SUM_W-1:0] csum_r [CHANNELS];
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0] prod;
  logic mac_v_r, mac_clr_r;
  logic [DQ_W-1:0] quo_r;
  logic [DQ_W:0]   rem_r;
  logic [$clog2(DQ_W+1)-1:0] dcnt_r;
  logic [CH_W-1:0] chi;
  logic [TP_W-1:0] tpi;
  logic [NW_W-1:0] widx;
  logic signed [15:0] win_s;
  logic [VAL_W-1:0] relu, mx;
  logic [DQ_W:0] trial;

  assign chi  = ch[CH_W-1:0];
  assign tpi  = tap[TP_W-1:0];
  assign widx = NW_W'(chi * TAPS + tpi);

  always_comb begin
    if (TAPS == 1 || 32'(tpi) == TAPS - 1) win_s = item_r.sample;
    else win_s = hist_r[HI_W'(tpi)];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) item_r <= in_item;
    if (in_item.kind == KIND_COEF && cmd.take_item) begin
      if (32'(in_item.coef_index) < NW)
        wmem[in_item.coef_index[NW_W-1:0]] <= in_item.coef_value;
      else if (32'(in_item.coef_index) < NW + CHANNELS)
        bmem[CH_W'(in_item.coef_index - 6'(NW))] <= in_item.coef_value;
    end
    w_rd_r <= wmem[widx];
    b_rd_r <= bmem[chi];
  end

  // weight, bias and window tap are registered together; the accumulator adds them in the cycle after
  assign prod = win_r * w_rd_r;

  always_ff @(posedge clk) begin
    mac_v_r   <= cmd.mac_step;
    mac_clr_r <= cmd.mac_clear;
    win_r     <= win_s;
    if (mac_v_r) begin
      if (mac_clr_r) acc_r <= (ACC_W'(b_rd_r) <<< 15) + ACC_W'(prod);
      else acc_r <= acc_r + ACC_W'(prod);
    end
  end

  always_comb begin
    if (acc_r <= 0) relu = '0;
    else if (acc_r > ACC_W'({VAL_W{1'b1}})) relu = '1;
    else relu = VAL_W'(acc_r);
    mx = (pfirst_r[chi] > relu) ? pfirst_r[chi] : relu;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.frame_clear) begin
      fill_r <= '0; scnt_r <= '0; phase_r <= 1'b0; pcnt_r <= '0;
      for (int i = 0; i < HIST; i++) hist_r[i] <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        pfirst_r[i] <= '0; csum_r[i] <= '0;
      end
    end else begin
      if (cmd.pool) begin
        if (!phase_r) pfirst_r[chi] <= relu;
        else csum_r[chi] <= csum_r[chi] + SUM_W'(mx);
      end
      if (cmd.win_shift) begin
        scnt_r <= scnt_r + 1'b1;
        if (32'(fill_r) < TAPS - 1) fill_r <= fill_r + 1'b1;
        else begin
          phase_r <= ~phase_r;
          if (phase_r) pcnt_r <= pcnt_r + 1'b1;
        end
        if (TAPS > 1) begin
          for (int j = 0; j + 1 < HIST; j++) hist_r[j] <= hist_r[j+1];
          hist_r[HIST-1] <= item_r.sample;
        end
      end
    end
  end

  // restoring divide, one quotient bit per step
  assign trial = {rem_r[DQ_W-1:0], quo_r[DQ_W-1]} - (DQ_W+1)'(pcnt_r);
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r <= csum_r[chi]; rem_r <= '0; dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 1'b1;
      if (!trial[DQ_W]) begin
        rem_r <= trial; quo_r <= {quo_r[DQ_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DQ_W-1:0], quo_r[DQ_W-1]}; quo_r <= {quo_r[DQ_W-2:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      res.channel      <= 4'(chi);
      res.mean_feature <= (pcnt_r == '0) ? '0 : VAL_W'(quo_r);
      res.last_result  <= (32'(chi) == CHANNELS - 1);
    end
  end

  assign stat.item_coef = (item_r.kind == KIND_COEF);
  assign stat.item_end  = item_r.frame_end;
  assign stat.item_drop = (32'(scnt_r) >= MAX_FRAME);
  assign stat.win_full  = (32'(fill_r) >= TAPS - 1);
  assign stat.div_done  = (32'(dcnt_r) == DQ_W);
endmodule
`default_nettype wire

// ----- hw/rtl/cra_ctrl.sv -----
`default_nettype none
module cra_ctrl
  import cra_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int TAPS     = TAPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  cra_stat_t stat,
  output cra_cmd_t  cmd,
  output logic [$clog2(CHANNELS+1)-1:0] ch,
  output logic [$clog2(TAPS+1)-1:0]     tap,
  output cra_state_t state
);
  localparam int CW = $clog2(CHANNELS+1);
  localparam int TW = $clog2(TAPS+1);
  cra_state_t state_r, state_nxt;
  logic [CW-1:0] ch_r, ch_nxt;
  logic [TW-1:0] tap_r, tap_nxt;
  logic busy_r, busy_nxt;   // item latched, not yet handled
  logic ov_r, ov_nxt;

  assign ch = ch_r; assign tap = tap_r; assign state = state_r;
  assign out_valid = ov_r;
  assign in_stall = (state_r != ST_IDLE) || busy_r;

  always_comb begin
    state_nxt = state_r; ch_nxt = ch_r; tap_nxt = tap_r;
    busy_nxt = busy_r; ov_nxt = ov_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) busy_nxt = 1'b1;
        else if (busy_r) begin
          busy_nxt = 1'b0;
          ch_nxt = '0; tap_nxt = '0;
          if (stat.item_coef) state_nxt = ST_IDLE;
          else if (!stat.item_drop && stat.win_full) state_nxt = ST_MAC;
          else if (stat.item_end) state_nxt = ST_LOAD;
        end
      end
      ST_MAC: begin
        if (32'(tap_r) == TAPS) state_nxt = ST_POOL;
        else tap_nxt = tap_r + 1'b1;
      end
      ST_POOL: begin
        tap_nxt = '0;
        if (32'(ch_r) == CHANNELS - 1) begin
          ch_nxt = '0;
          state_nxt = stat.item_end ? ST_LOAD : ST_IDLE;
        end else begin
          ch_nxt = ch_r + 1'b1; state_nxt = ST_MAC;
        end
      end
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: if (stat.div_done && !ov_r) state_nxt = ST_EMIT;
      ST_EMIT: begin
        ov_nxt = 1'b1;
        if (32'(ch_r) == CHANNELS - 1) begin
          ch_nxt = '0; state_nxt = ST_IDLE;
        end else begin
          ch_nxt = ch_r + 1'b1; state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // window shifts when a non-dropped sample is decided while the window fills, or after the last channel is pooled
  always_comb begin
    cmd = '0;
    cmd.take_item = in_valid && !in_stall;
    unique case (state_r)
      ST_IDLE: if (busy_r && !stat.item_coef && !stat.item_drop && !stat.win_full)
        cmd.win_shift = 1'b1;
      ST_MAC: begin
        cmd.mac_clear = (tap_r == '0);
        cmd.mac_step  = (32'(tap_r) < TAPS);
      end
      ST_POOL: begin
        cmd.pool = 1'b1;
        cmd.win_shift = (32'(ch_r) == CHANNELS - 1);
      end
      ST_LOAD: cmd.div_start = 1'b1;
      ST_DIV: cmd.div_step = !stat.div_done;
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.frame_clear = (32'(ch_r) == CHANNELS - 1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; ch_r <= '0; tap_r <= '0; busy_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ch_r <= ch_nxt; tap_r <= tap_nxt;
      busy_r <= busy_nxt; ov_r <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/conv1d_relu_maxpool_avgpool_core.sv -----
`default_nettype none
// channel | direction | handshake          | payload
// in_     | input     | in_valid/in_stall  | cra_in_t
// out_    | output    | out_valid/out_stall| cra_out_t
// A coefficient transfer, or a sample that only fills the window or is dropped, is
// taken and decided in IDLE. For a sample with a full window, one shared
// multiplier walks every tap of every channel in turn. A frame end adds, per
// channel: load, 46 divide steps, done check, result.
// Reset is synchronous, active low, and clears all frame state at once. A stalled
// result holds; the divider waits for the output register to empty.
module conv1d_relu_maxpool_avgpool_core
  import cra_pkg::*;
#(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int TAPS      = TAPS_DEF,
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  cra_in_t   in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output cra_out_t  out_data
);
  cra_cmd_t   cmd;
  cra_stat_t  stat;
  cra_state_t state;
  logic [$clog2(CHANNELS+1)-1:0] ch;
  logic [$clog2(TAPS+1)-1:0]     tap;

  cra_ctrl #(.CHANNELS(CHANNELS), .TAPS(TAPS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .stat, .cmd, .ch, .tap, .state
  );

  cra_datapath #(.CHANNELS(CHANNELS), .TAPS(TAPS), .MAX_FRAME(MAX_FRAME)) u_dp (
    .clk, .rst_n, .in_item(in_data), .cmd, .ch, .tap, .stat, .res(out_data)
  );

  // no intake while a frame's results are in progress
  a_no_take_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_LOAD || state == ST_DIV || state == ST_EMIT) |-> in_stall)
    else $error("intake during emit");
  // a new result is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || !out_stall)) else $error("result overwritten");
  // pooling and dividing never overlap
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.pool && cmd.div_step)) else $error("pool and divide overlap");
endmodule
`default_nettype wire
